FILE: rtl/brkd_pkg.sv
// Shared types and codes for the bounded recent-key dedup counter.
`default_nettype none
package brkd_pkg;

  localparam int unsigned KeyWidth = 64;
  localparam int unsigned CountWidth = 32;

  typedef enum logic [1:0] {
    ACT_READBACK = 2'd0,
    ACT_SURFACE  = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [KeyWidth-1:0]   key;
  } req_t;

  typedef struct packed {
    logic                  key_was_new;
    logic [CountWidth-1:0] total_readbacks;
    logic [CountWidth-1:0] unique_surfaces;
    logic [CountWidth-1:0] redundant_readbacks;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/brkd_ctrl.sv
// Controller state machine: sequences load, key scan and commit of one request.
`default_nettype none
module brkd_ctrl
  import brkd_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = stat.need_scan ? ST_SCAN : ST_COMMIT;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/brkd_dp.sv
// Datapath: key memory, ring pointers, saturating counters and result register.
`default_nettype none
module brkd_dp
  import brkd_pkg::*;
#(
  parameter int unsigned TRACK_LIMIT = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire   clk,
  input  wire   rst,
  input  req_t  req_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  rsp_valid,
  input  wire   rsp_ready,
  output rsp_t  rsp_data
);

  localparam int unsigned IW = (TRACK_LIMIT > 1) ? $clog2(TRACK_LIMIT) : 1;
  localparam int unsigned CW = $clog2(TRACK_LIMIT + 1);
  localparam int unsigned AW = IW + 1;
  localparam int unsigned Depth = 2 ** AW;
  localparam logic [CW-1:0] Limit = CW'(TRACK_LIMIT);
  localparam logic [IW-1:0] LastSlot = IW'(TRACK_LIMIT - 1);
  localparam logic [CountWidth-1:0] CountMax = '1;

  logic [KEY_BITS-1:0] mem [0:Depth-1];

  action_t             act;
  logic [KEY_BITS-1:0] key_q;
  logic [IW-1:0]       scan_idx;
  logic [KEY_BITS-1:0] rd_data;
  logic                rd_valid;
  logic                hit;

  logic [CW-1:0]       rb_occ;
  logic [CW-1:0]       sf_occ;
  logic [IW-1:0]       rb_oldest;
  logic [IW-1:0]       sf_oldest;
  logic [CountWidth-1:0] total_cnt;
  logic [CountWidth-1:0] unique_cnt;
  logic [CountWidth-1:0] repeat_cnt;

  logic [CountWidth-1:0] total_cnt_next;
  logic [CountWidth-1:0] unique_cnt_next;
  logic [CountWidth-1:0] repeat_cnt_next;

  logic                set_sel;
  logic [CW-1:0]       occ_sel;
  logic [IW-1:0]       oldest_sel;
  logic                full;
  logic                insert;
  logic [IW-1:0]       wr_idx;
  logic [CW-1:0]       occ_new;
  logic [IW-1:0]       oldest_new;

  assign set_sel    = (act == ACT_SURFACE);
  assign occ_sel    = set_sel ? sf_occ : rb_occ;
  assign oldest_sel = set_sel ? sf_oldest : rb_oldest;
  assign full       = (occ_sel == Limit);
  assign insert     = ((act == ACT_READBACK) || (act == ACT_SURFACE)) && !hit;
  assign wr_idx     = full ? oldest_sel : occ_sel[IW-1:0];
  assign occ_new    = full ? occ_sel : occ_sel + CW'(1);
  assign oldest_new = !full ? oldest_sel :
                      (oldest_sel == LastSlot) ? '0 : oldest_sel + IW'(1);

  assign stat.need_scan = ((act == ACT_READBACK) || (act == ACT_SURFACE)) && (occ_sel != '0);
  assign stat.scan_last = (CW'(scan_idx) + CW'(1)) == occ_sel;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= req_data.action;
      key_q <= req_data.key[KEY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[{set_sel, scan_idx}];
    end
    if (cmd.commit && insert) begin
      mem[{set_sel, wr_idx}] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
      hit      <= 1'b0;
    end else begin
      if (cmd.scan) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (rd_valid && (rd_data == key_q)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
    end
  end

  always_comb begin
    total_cnt_next  = total_cnt;
    unique_cnt_next = unique_cnt;
    repeat_cnt_next = repeat_cnt;
    case (act)
      ACT_READBACK: begin
        if (total_cnt != CountMax) begin
          total_cnt_next = total_cnt + CountWidth'(1);
        end
        if (hit && (repeat_cnt != CountMax)) begin
          repeat_cnt_next = repeat_cnt + CountWidth'(1);
        end
      end
      ACT_SURFACE: begin
        if (!hit && (unique_cnt != CountMax)) begin
          unique_cnt_next = unique_cnt + CountWidth'(1);
        end
      end
      ACT_CLEAR: begin
        total_cnt_next  = '0;
        unique_cnt_next = '0;
        repeat_cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_occ     <= '0;
      sf_occ     <= '0;
      rb_oldest  <= '0;
      sf_oldest  <= '0;
      total_cnt  <= '0;
      unique_cnt <= '0;
      repeat_cnt <= '0;
    end else if (cmd.commit) begin
      total_cnt  <= total_cnt_next;
      unique_cnt <= unique_cnt_next;
      repeat_cnt <= repeat_cnt_next;
      if (act == ACT_CLEAR) begin
        rb_occ    <= '0;
        sf_occ    <= '0;
        rb_oldest <= '0;
        sf_oldest <= '0;
      end else if (insert && set_sel) begin
        sf_occ    <= occ_new;
        sf_oldest <= oldest_new;
      end else if (insert) begin
        rb_occ    <= occ_new;
        rb_oldest <= oldest_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.key_was_new         <= insert;
      rsp_data.total_readbacks     <= total_cnt_next;
      rsp_data.unique_surfaces     <= unique_cnt_next;
      rsp_data.redundant_readbacks <= repeat_cnt_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bounded_recent_key_dedup_counter_top.sv
// Top level of the bounded recent-key dedup counter.
//
//   channel  signals                         carries
//   req      req_valid, req_ready, req_data   action and key
//   rsp      rsp_valid, rsp_ready, rsp_data   new flag and three counters
//
// A request goes through start, scan, drain and commit between acceptances; the scan
// makes one key memory read per cycle, one per key held in the addressed set (up to
// TRACK_LIMIT). Clear, unused actions and an empty set skip scan and drain.
// Reset empties both sets and zeroes the counters at once; no clearing pass.
// A result held by rsp_ready low does not block the next request until its commit.
`default_nettype none
module bounded_recent_key_dedup_counter_top
  import brkd_pkg::*;
#(
  parameter int unsigned TRACK_LIMIT = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp_data
);

  cmd_t  cmd;
  stat_t stat;

  brkd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brkd_dp #(
    .TRACK_LIMIT (TRACK_LIMIT),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire
